// ===== rtl/crfab_pkg.sv =====
// shared constants, types and the blend function of the rectangle fill unit
package crfab_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PIX_DEPTH     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(PIX_DEPTH);
    localparam int COL_W         = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT + 1);
    localparam int CLR_W         = ADDR_W + 1;

    localparam int ORIGIN_W      = 12;
    localparam int SIZE_W        = 11;
    localparam int PIX_W         = 32;
    localparam int RD_COORD_W    = 6;
    localparam int COUNT_W       = 13;
    localparam int CLIP_W        = ORIGIN_W + 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [7:0]         CHANNEL_MAX = 8'hff;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        pix_t  wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic   kind;
        pix_t   pix;
        count_t count;
    } result_t;

    function automatic pix_t add_blend(input pix_t old_pix, input pix_t col);
        logic [8:0] sum;
        pix_t       res;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = {1'b0, old_pix[ch*8 +: 8]} + {1'b0, col[ch*8 +: 8]};
            res[ch*8 +: 8] = sum[8] ? CHANNEL_MAX : sum[7:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/crfab_if.sv =====
// valid/ready channel interfaces for command and result words
interface crfab_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic signed [crfab_pkg::ORIGIN_W-1:0]  origin_x;
    logic signed [crfab_pkg::ORIGIN_W-1:0]  origin_y;
    logic [crfab_pkg::SIZE_W-1:0]           rect_width;
    logic [crfab_pkg::SIZE_W-1:0]           rect_height;
    logic [crfab_pkg::PIX_W-1:0]            fill_color;
    logic                                   additive;
    logic [crfab_pkg::RD_COORD_W-1:0]       read_col;
    logic [crfab_pkg::RD_COORD_W-1:0]       read_row;

    modport source (
        output valid, kind, origin_x, origin_y, rect_width, rect_height,
               fill_color, additive, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, kind, origin_x, origin_y, rect_width, rect_height,
               fill_color, additive, read_col, read_row,
        output ready
    );
endinterface

interface crfab_res_if;
    logic                               valid;
    logic                               ready;
    logic                               result_kind;
    logic [crfab_pkg::PIX_W-1:0]        pixel_value;
    logic [crfab_pkg::COUNT_W-1:0]      pixels_written;

    modport source (
        output valid, result_kind, pixel_value, pixels_written,
        input  ready
    );
    modport sink (
        input  valid, result_kind, pixel_value, pixels_written,
        output ready
    );
endinterface

// ===== rtl/clipped_rect_fill_additive_blend_unit.sv =====
// top level of the clipped rectangle fill unit with saturating add blend
// A command word either fills a rectangle, clipped to the 64 by 64 pixel
// screen, or reads back one pixel; every command returns exactly one result
// word. After reset the unit clears its framebuffer, one pixel a cycle, before
// it takes the first command. The framebuffer memory does one read and one
// write a cycle, so a fill walks the clipped pixels at one read-modify-write
// per cycle, then lets its last write drain before it offers its result word;
// a read offers its result once the registered read data is captured. The next
// command is taken once the previous one has moved its result word into the
// output register, even while that word waits.
module clipped_rect_fill_additive_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    crfab_cmd_if.sink   cmd,
    crfab_res_if.source rsp
);

    crfab_pkg::ram_req_t ram_req;
    crfab_pkg::pix_t     ram_rdata;
    crfab_pkg::result_t  res;
    logic                res_valid;
    logic                res_ready;

    logic                out_valid_reg, out_valid_next;
    crfab_pkg::result_t  out_reg, out_next;

    crfab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    crfab_frame_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_kind    = out_reg.kind;
    assign rsp.pixel_value    = out_reg.pix;
    assign rsp.pixels_written = out_reg.count;

endmodule

// ===== rtl/crfab_frame_ram.sv =====
// framebuffer memory, one write port and one registered read port
module crfab_frame_ram (
    input  logic                  clk,
    input  crfab_pkg::ram_req_t   req,
    output crfab_pkg::pix_t       rdata
);

    crfab_pkg::pix_t mem [crfab_pkg::PIX_DEPTH];
    crfab_pkg::pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/crfab_ctrl.sv =====
// clipping, pixel walk, read-modify-write pipeline and clearing pass
module crfab_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    crfab_cmd_if.sink             cmd,
    output crfab_pkg::result_t    res,
    output logic                  res_valid,
    input  logic                  res_ready,
    output crfab_pkg::ram_req_t   ram_req,
    input  crfab_pkg::pix_t       ram_rdata
);

    localparam int CW = crfab_pkg::CLIP_W;
    localparam logic signed [CW-1:0] W_S = CW'(crfab_pkg::SCREEN_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(crfab_pkg::SCREEN_HEIGHT);

    crfab_pkg::state_t state_reg, state_next;

    logic [crfab_pkg::CLR_W-1:0]  clr_reg, clr_next;
    logic [crfab_pkg::COL_W-1:0]  col_reg, col_next;
    logic [crfab_pkg::COL_W-1:0]  col_lo_reg, col_lo_next;
    logic [crfab_pkg::COL_W-1:0]  col_hi_reg, col_hi_next;
    logic [crfab_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [crfab_pkg::ROW_W-1:0]  row_hi_reg, row_hi_next;
    crfab_pkg::addr_t             base_reg, base_next;
    crfab_pkg::count_t            count_reg, count_next;
    crfab_pkg::pix_t              color_reg, color_next;
    logic                         add_reg, add_next;
    logic                         kind_reg, kind_next;
    logic                         in_range_reg, in_range_next;
    crfab_pkg::pix_t              pix_reg, pix_next;
    logic                         p_valid_reg, p_valid_next;
    crfab_pkg::addr_t             p_addr_reg, p_addr_next;

    logic signed [CW-1:0] ox, oy, ex, ey, x0, x1, y0, y1;
    logic                 empty;
    crfab_pkg::addr_t     walk_addr, rd_addr;
    logic                 rd_ok;

    // clip window of the incoming rectangle
    always_comb
    begin
        ox = CW'(cmd.origin_x);
        oy = CW'(cmd.origin_y);
        ex = ox + CW'(cmd.rect_width);
        ey = oy + CW'(cmd.rect_height);
        x0 = (ox < 0) ? '0 : ox;
        y0 = (oy < 0) ? '0 : oy;
        x1 = (ex > W_S) ? W_S : ex;
        y1 = (ey > H_S) ? H_S : ey;
        empty = (x1 <= x0) || (y1 <= y0);
    end

    assign walk_addr = base_reg + crfab_pkg::ADDR_W'(col_reg);
    assign rd_addr   = crfab_pkg::ADDR_W'(crfab_pkg::ADDR_W'(cmd.read_row)
                       * crfab_pkg::ADDR_W'(crfab_pkg::SCREEN_WIDTH))
                       + crfab_pkg::ADDR_W'(cmd.read_col);
    assign rd_ok     = (32'(cmd.read_col) < 32'(crfab_pkg::SCREEN_WIDTH))
                    && (32'(cmd.read_row) < 32'(crfab_pkg::SCREEN_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crfab_pkg::ST_CLEAR;
            clr_reg     <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        col_lo_reg   <= col_lo_next;
        col_hi_reg   <= col_hi_next;
        row_reg      <= row_next;
        row_hi_reg   <= row_hi_next;
        base_reg     <= base_next;
        count_reg    <= count_next;
        color_reg    <= color_next;
        add_reg      <= add_next;
        kind_reg     <= kind_next;
        in_range_reg <= in_range_next;
        pix_reg      <= pix_next;
        p_addr_reg   <= p_addr_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        col_next      = col_reg;
        col_lo_next   = col_lo_reg;
        col_hi_next   = col_hi_reg;
        row_next      = row_reg;
        row_hi_next   = row_hi_reg;
        base_next     = base_reg;
        count_next    = count_reg;
        color_next    = color_reg;
        add_next      = add_reg;
        kind_next     = kind_reg;
        in_range_next = in_range_reg;
        pix_next      = pix_reg;
        p_valid_next  = 1'b0;
        p_addr_next   = p_addr_reg;
        cmd.ready     = 1'b0;
        res_valid     = 1'b0;
        ram_req       = '0;

        // write stage of the read-modify-write pipeline
        if (p_valid_reg)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = p_addr_reg;
            ram_req.wdata = add_reg ? crfab_pkg::add_blend(ram_rdata, color_reg)
                                    : color_reg;
        end

        case (state_reg)
            crfab_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg[crfab_pkg::ADDR_W-1:0];
                ram_req.wdata = '0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == crfab_pkg::CLR_W'(crfab_pkg::PIX_DEPTH - 1))
                begin
                    state_next = crfab_pkg::ST_IDLE;
                end
            end
            crfab_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    count_next = '0;
                    pix_next   = '0;
                    if (cmd.kind == crfab_pkg::KIND_READ)
                    begin
                        in_range_next = rd_ok;
                        ram_req.re    = 1'b1;
                        ram_req.raddr = rd_addr;
                        state_next    = crfab_pkg::ST_READ;
                    end
                    else
                    begin
                        col_lo_next = crfab_pkg::COL_W'(x0);
                        col_next    = crfab_pkg::COL_W'(x0);
                        col_hi_next = crfab_pkg::COL_W'(x1);
                        row_next    = crfab_pkg::ROW_W'(y0);
                        row_hi_next = crfab_pkg::ROW_W'(y1);
                        base_next   = crfab_pkg::ADDR_W'(crfab_pkg::ADDR_W'(y0)
                                      * crfab_pkg::ADDR_W'(crfab_pkg::SCREEN_WIDTH));
                        color_next  = cmd.fill_color;
                        add_next    = cmd.additive;
                        state_next  = empty ? crfab_pkg::ST_DONE : crfab_pkg::ST_FILL;
                    end
                end
            end
            crfab_pkg::ST_FILL:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = walk_addr;
                p_valid_next  = 1'b1;
                p_addr_next   = walk_addr;
                if (count_reg != crfab_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (col_reg + 1'b1 == col_hi_reg)
                begin
                    col_next  = col_lo_reg;
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + crfab_pkg::ADDR_W'(crfab_pkg::SCREEN_WIDTH);
                    if (row_reg + 1'b1 == row_hi_reg)
                    begin
                        state_next = crfab_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            crfab_pkg::ST_DRAIN:
            begin
                state_next = crfab_pkg::ST_DONE;
            end
            crfab_pkg::ST_READ:
            begin
                pix_next   = in_range_reg ? ram_rdata : '0;
                state_next = crfab_pkg::ST_DONE;
            end
            crfab_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = crfab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crfab_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.kind  = kind_reg;
    assign res.pix   = pix_reg;
    assign res.count = count_reg;

endmodule

// ===== sim/crfab_frame_checker.sv =====
// checker that mirrors the framebuffer, predicts each result word and compares it
module crfab_frame_checker
    import crfab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    crfab_cmd_if cmd,
    crfab_res_if rsp,
    output int   error_count,
    output int   words_in_flight
);

    pix_t    frame_copy [PIX_DEPTH];
    result_t expected_words [$];
    result_t want;

    function automatic count_t paint_rect(
        input logic signed [ORIGIN_W-1:0] org_x,
        input logic signed [ORIGIN_W-1:0] org_y,
        input logic [SIZE_W-1:0]          wid,
        input logic [SIZE_W-1:0]          hgt,
        input pix_t                       color,
        input logic                       add_mode
    );
        int   x0;
        int   x1;
        int   y0;
        int   y1;
        int   painted;
        int   sum;
        pix_t old_pix;
        pix_t new_pix;
        x0 = (org_x < 0) ? 0 : int'(org_x);
        y0 = (org_y < 0) ? 0 : int'(org_y);
        x1 = int'(org_x) + int'(wid);
        y1 = int'(org_y) + int'(hgt);
        if (x1 > SCREEN_WIDTH)
            x1 = SCREEN_WIDTH;
        if (y1 > SCREEN_HEIGHT)
            y1 = SCREEN_HEIGHT;
        painted = 0;
        for (int r = y0; r < y1; r++)
            for (int c = x0; c < x1; c++)
            begin
                old_pix = frame_copy[r * SCREEN_WIDTH + c];
                if (add_mode)
                begin
                    // per-channel saturating add, top byte cleared
                    new_pix = '0;
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        sum = int'(old_pix[ch*8 +: 8]) + int'(color[ch*8 +: 8]);
                        new_pix[ch*8 +: 8] = (sum > int'(CHANNEL_MAX))
                                             ? CHANNEL_MAX : 8'(sum);
                    end
                end
                else
                    new_pix = color;
                frame_copy[r * SCREEN_WIDTH + c] = new_pix;
                if (painted < int'(COUNT_MAX))
                    painted++;
            end
        return count_t'(painted);
    endfunction

    task automatic log_mismatch(input string what);
        error_count++;
        if (error_count <= 10)
            $display("mismatch (%s): exp kind=%0d pix=%h cnt=%0d, got kind=%0d pix=%h cnt=%0d",
                     what, want.kind, want.pix, want.count,
                     rsp.result_kind, rsp.pixel_value, rsp.pixels_written);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_copy[i])
                frame_copy[i] = '0;
            expected_words.delete();
            error_count     = 0;
            words_in_flight = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    want = '0;
                    log_mismatch("no word pending");
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.result_kind !== want.kind || rsp.pixel_value !== want.pix ||
                        rsp.pixels_written !== want.count)
                        log_mismatch("field");
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                want.kind  = cmd.kind;
                want.pix   = '0;
                want.count = '0;
                if (cmd.kind == KIND_FILL)
                    want.count = paint_rect(cmd.origin_x, cmd.origin_y, cmd.rect_width,
                                            cmd.rect_height, cmd.fill_color, cmd.additive);
                else if (int'(cmd.read_col) < SCREEN_WIDTH && int'(cmd.read_row) < SCREEN_HEIGHT)
                    want.pix = frame_copy[int'(cmd.read_row) * SCREEN_WIDTH + int'(cmd.read_col)];
                expected_words.push_back(want);
            end
            words_in_flight = expected_words.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// stimulus, clock, reset and verdict for the clipped rectangle fill unit
module tb;
    import crfab_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_WORDS = 118;

    typedef struct {
        logic                        kind;
        logic signed [ORIGIN_W-1:0]  org_x;
        logic signed [ORIGIN_W-1:0]  org_y;
        logic [SIZE_W-1:0]           wid;
        logic [SIZE_W-1:0]           hgt;
        pix_t                        color;
        logic                        add_mode;
        logic [RD_COORD_W-1:0]       rd_col;
        logic [RD_COORD_W-1:0]       rd_row;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   words_in_flight;
    int   cycle_count = 0;
    int   stall_left  = 0;
    int   regime      = 0;
    int   regime_left = 0;

    bit   region_valid = 1'b0;
    int   region_x0;
    int   region_x1;
    int   region_y0;
    int   region_y1;

    crfab_cmd_if cmd_ch ();
    crfab_res_if res_ch ();

    clipped_rect_fill_additive_blend_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (res_ch)
    );

    crfab_frame_checker i_frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .rsp             (res_ch),
        .error_count     (fail_count),
        .words_in_flight (words_in_flight)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        else if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // result side back-pressure, in stretches of none, light and heavy stalling
    always @(posedge clk)
    begin
        if (regime_left == 0)
        begin
            regime      <= $urandom_range(2, 0);
            regime_left <= $urandom_range(400, 50);
        end
        else
            regime_left <= regime_left - 1;
        if (stall_left != 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (regime != 0 && $urandom_range(99, 0) < ((regime == 1) ? 15 : 50))
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= pick_gap();
        end
        else
            res_ch.ready <= 1'b1;
    end

    function automatic cmd_word_t make_fill(input int ox, input int oy, input int w,
                                            input int h, input pix_t color, input logic add);
        cmd_word_t word;
        word.kind     = KIND_FILL;
        word.org_x    = ORIGIN_W'(ox);
        word.org_y    = ORIGIN_W'(oy);
        word.wid      = SIZE_W'(w);
        word.hgt      = SIZE_W'(h);
        word.color    = color;
        word.add_mode = add;
        word.rd_col   = RD_COORD_W'($urandom);
        word.rd_row   = RD_COORD_W'($urandom);
        return word;
    endfunction

    function automatic cmd_word_t make_read(input int col, input int row);
        cmd_word_t word;
        word          = make_fill($urandom, $urandom, $urandom, $urandom, $urandom,
                                  1'($urandom));
        word.kind     = KIND_READ;
        word.rd_col   = RD_COORD_W'(col);
        word.rd_row   = RD_COORD_W'(row);
        return word;
    endfunction

    function automatic cmd_word_t random_word();
        int   sel;
        int   ox;
        int   oy;
        int   w;
        int   h;
        pix_t color;
        if ($urandom_range(99, 0) < 35)
        begin
            // about half the time, read back a pixel of the latest non-empty fill
            if (region_valid && $urandom_range(1, 0))
                return make_read($urandom_range(region_x1 - 1, region_x0),
                                 $urandom_range(region_y1 - 1, region_y0));
            return make_read($urandom, $urandom);
        end
        sel = $urandom_range(99, 0);
        if (sel < 85)
        begin
            ox = int'($urandom_range(72, 0)) - 16;
            oy = int'($urandom_range(72, 0)) - 16;
            w  = $urandom_range(20, 0);
            h  = $urandom_range(20, 0);
        end
        else if (sel < 95)
        begin
            ox = int'($urandom_range(128, 0)) - 64;
            oy = int'($urandom_range(128, 0)) - 64;
            w  = $urandom_range(80, 0);
            h  = $urandom_range(80, 0);
        end
        else
        begin
            ox = $urandom;
            oy = $urandom;
            w  = $urandom;
            h  = $urandom;
        end
        color = $urandom;
        if ($urandom_range(2, 0) == 0)
            color = color | 32'h00c0_c0c0;
        return make_fill(ox, oy, w, h, color, 1'($urandom_range(1, 0)));
    endfunction

    task automatic send_word(input cmd_word_t word);
        int x0;
        int x1;
        int y0;
        int y1;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= word.kind;
        cmd_ch.origin_x    <= word.org_x;
        cmd_ch.origin_y    <= word.org_y;
        cmd_ch.rect_width  <= word.wid;
        cmd_ch.rect_height <= word.hgt;
        cmd_ch.fill_color  <= word.color;
        cmd_ch.additive    <= word.add_mode;
        cmd_ch.read_col    <= word.rd_col;
        cmd_ch.read_row    <= word.rd_row;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (word.kind == KIND_FILL)
        begin
            x0 = (word.org_x < 0) ? 0 : int'(word.org_x);
            y0 = (word.org_y < 0) ? 0 : int'(word.org_y);
            x1 = int'(word.org_x) + int'(word.wid);
            y1 = int'(word.org_y) + int'(word.hgt);
            if (x1 > SCREEN_WIDTH)
                x1 = SCREEN_WIDTH;
            if (y1 > SCREEN_HEIGHT)
                y1 = SCREEN_HEIGHT;
            if (x0 < x1 && y0 < y1)
            begin
                region_valid = 1'b1;
                region_x0    = x0;
                region_x1    = x1;
                region_y0    = y0;
                region_y1    = y1;
            end
        end
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (words_in_flight != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int burst_left;
        burst_left         = 0;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.kind        <= KIND_FILL;
        cmd_ch.origin_x    <= '0;
        cmd_ch.origin_y    <= '0;
        cmd_ch.rect_width  <= '0;
        cmd_ch.rect_height <= '0;
        cmd_ch.fill_color  <= '0;
        cmd_ch.additive    <= 1'b0;
        cmd_ch.read_col    <= '0;
        cmd_ch.read_row    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // cleared store, full screen overwrite and full screen add
        send_word(make_read(0, 0));
        send_word(make_read(63, 63));
        send_word(make_fill(0, 0, 64, 64, 32'ha010_80f0, 1'b0));
        send_word(make_read(63, 63));
        hold_off(pick_gap());
        send_word(make_fill(-10, -5, 2047, 2047, 32'h5a90_9020, 1'b1));
        send_word(make_read(31, 17));
        // empty and fully clipped rectangles
        send_word(make_fill(3, 3, 0, 5, 32'h1234_5678, 1'b0));
        send_word(make_fill(3, 3, 5, 0, 32'h1234_5678, 1'b1));
        send_word(make_fill(-100, 4, 50, 4, 32'h1111_1111, 1'b0));
        hold_off(pick_gap());
        send_word(make_fill(64, 4, 10, 4, 32'h2222_2222, 1'b0));
        send_word(make_fill(4, -20, 4, 20, 32'h3333_3333, 1'b0));
        send_word(make_fill(4, 64, 4, 4, 32'h4444_4444, 1'b1));
        send_word(make_fill(-2048, -2048, 2047, 2047, 32'h0000_0000, 1'b1));
        send_word(make_fill(2047, 2047, 2047, 2047, 32'hffff_ffff, 1'b0));
        // partial clipping on the left, right and bottom edges, saturation and top byte clearing
        send_word(make_fill(-3, 10, 8, 2, 32'hffff_ffff, 1'b0));
        send_word(make_read(0, 10));
        hold_off(pick_gap());
        send_word(make_fill(60, 62, 10, 5, 32'hff01_007f, 1'b1));
        send_word(make_read(63, 63));
        send_word(make_fill(63, 63, 1, 1, 32'h0000_0000, 1'b0));
        send_word(make_read(63, 63));
        send_word(make_fill(1, 10, 1, 1, 32'h0101_0101, 1'b1));
        send_word(make_read(1, 10));
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            send_word(random_word());
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(99, 0) < 10)
                burst_left = $urandom_range(15, 5);
            else
                hold_off(pick_gap());
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && words_in_flight == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/crfab_pkg.sv
rtl/crfab_if.sv
rtl/crfab_frame_ram.sv
rtl/crfab_ctrl.sv
rtl/clipped_rect_fill_additive_blend_unit.sv
sim/crfab_frame_checker.sv
sim/tb.sv
